// ===== src/homogeneous_point_transform_macros.svh =====
// Assertion shorthands for the checker file of this block.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH

// Checked on every rising edge outside reset.
`define HPT_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define HPT_ASSERT(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/hpt_pkg.sv =====
package hpt_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * WORD_BITS;
    localparam int SUM_W     = PROD_W + 2;
    // Floor of a three-term sum plus one matrix entry.
    localparam int V_W       = SUM_W - FRAC_BITS + 1;
    localparam int SQ_W      = PROD_W;
    localparam int LANE_Q    = WORD_BITS;
    localparam int RAY_Q     = WORD_BITS - 1;

    typedef logic signed [WORD_BITS-1:0] word_t;

    localparam word_t RES_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t RES_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam word_t ONE_Q   = word_t'(64'd1 << FRAC_BITS);

    typedef enum logic [2:0] {
        CMD_LOAD   = 3'd0,
        CMD_POINT  = 3'd1,
        CMD_VECTOR = 3'd2,
        CMD_NORMAL = 3'd3,
        CMD_RAY    = 3'd4
    } cmd_t;

    typedef struct packed {
        logic divide;
        logic ray;
    } mode_t;

    typedef struct packed {
        word_t                r_x;
        word_t                r_y;
        word_t                r_z;
        word_t                s_x;
        word_t                s_y;
        word_t                s_z;
        logic [WORD_BITS-2:0] t_max;
        logic                 div_error;
    } result_t;

    function automatic word_t sat_word(input logic signed [V_W-1:0] v);
        logic signed [V_W-1:0] hi;
        logic signed [V_W-1:0] lo;
        hi = V_W'(RES_MAX);
        lo = V_W'(RES_MIN);
        if (v > hi) begin
            return RES_MAX;
        end else if (v < lo) begin
            return RES_MIN;
        end
        return v[WORD_BITS-1:0];
    endfunction

endpackage

// ===== src/hpt_div.sv =====
module hpt_div #(
    parameter int NUM_W  = 51,
    parameter int Q_BITS = 32
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [NUM_W-1:0]  num,
    input  logic [NUM_W-1:0]  den,
    output logic [Q_BITS-1:0] quo,
    output logic              ovf
);
    import hpt_pkg::*;

    localparam int NQ_W = NUM_W + FRAC_BITS;

    logic [NQ_W-1:0]   nq;
    logic [NQ_W-1:0]   head;
    logic              ovf0;
    logic [NUM_W-1:0]  rem_reg [0:Q_BITS];
    logic [Q_BITS-1:0] low_reg [0:Q_BITS];
    logic [Q_BITS-1:0] quo_reg [0:Q_BITS];
    logic [NUM_W-1:0]  den_reg [0:Q_BITS];
    logic              ovf_reg [0:Q_BITS];
    logic [NUM_W:0]    trial   [1:Q_BITS];
    logic              take    [1:Q_BITS];

    // The quotient must fit in Q_BITS bits; otherwise the caller saturates.
    always_comb begin
        nq   = {num, {FRAC_BITS{1'b0}}};
        head = nq >> Q_BITS;
        ovf0 = head >= NQ_W'(den);
        for (int k = 1; k <= Q_BITS; k++) begin
            trial[k] = {rem_reg[k-1], low_reg[k-1][Q_BITS-1]};
            take[k]  = trial[k] >= {1'b0, den_reg[k-1]};
        end
    end

    // One restoring step per stage, one quotient bit each.
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= head[NUM_W-1:0];
            low_reg[0] <= nq[Q_BITS-1:0];
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            ovf_reg[0] <= ovf0;
            for (int k = 1; k <= Q_BITS; k++) begin
                rem_reg[k] <= take[k] ? NUM_W'(trial[k] - {1'b0, den_reg[k-1]})
                                      : trial[k][NUM_W-1:0];
                low_reg[k] <= low_reg[k-1] << 1;
                quo_reg[k] <= {quo_reg[k-1][Q_BITS-2:0], take[k]};
                den_reg[k] <= den_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign quo = quo_reg[Q_BITS];
    assign ovf = ovf_reg[Q_BITS];

endmodule

// ===== src/hpt_lane.sv =====
module hpt_lane (
    input  logic                         aclk,
    input  logic                         en,
    input  hpt_pkg::word_t               coef [4],
    input  hpt_pkg::word_t               a    [3],
    input  hpt_pkg::word_t               b    [3],
    input  hpt_pkg::mode_t               mode,
    input  logic signed [hpt_pkg::V_W-1:0] w,
    output hpt_pkg::word_t               s_mid,
    output hpt_pkg::word_t               r_out,
    output hpt_pkg::word_t               s_out
);
    import hpt_pkg::*;

    localparam int SIDE_N = LANE_Q + 2;
    localparam int S_N    = LANE_Q + 3;
    localparam logic [WORD_BITS:0] LIM_POS = {2'b00, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS:0] LIM_NEG = {2'b01, {(WORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic  div;
        logic  neg;
        word_t byp;
    } lane_side_t;

    logic signed [PROD_W-1:0] pa_reg [3];
    logic signed [PROD_W-1:0] pb_reg [3];
    word_t                    c3_1_reg;
    word_t                    c3_2_reg;
    mode_t                    m1_reg;
    mode_t                    m2_reg;
    mode_t                    m3_reg;
    logic signed [SUM_W-1:0]  suma_reg;
    logic signed [SUM_W-1:0]  sumb_reg;
    logic signed [V_W-1:0]    v_reg;
    word_t                    sv_reg;
    logic [V_W-1:0]           num4_reg;
    logic [V_W-1:0]           den4_reg;
    lane_side_t               side4;
    lane_side_t               side_reg [SIDE_N];
    word_t                    s_reg [S_N];
    logic [LANE_Q-1:0]        quo;
    logic                     ovf;
    logic                     w_one;
    logic                     w_zero;
    logic [WORD_BITS:0]       lim;
    logic [WORD_BITS:0]       mag;
    logic [WORD_BITS:0]       sres;
    word_t                    r_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                pa_reg[j] <= PROD_W'(coef[j]) * PROD_W'(a[j]);
                pb_reg[j] <= PROD_W'(coef[j]) * PROD_W'(b[j]);
            end
            c3_1_reg <= coef[3];
            m1_reg   <= mode;
            suma_reg <= SUM_W'(pa_reg[0]) + SUM_W'(pa_reg[1]) + SUM_W'(pa_reg[2]);
            sumb_reg <= SUM_W'(pb_reg[0]) + SUM_W'(pb_reg[1]) + SUM_W'(pb_reg[2]);
            c3_2_reg <= c3_1_reg;
            m2_reg   <= m1_reg;
            // The arithmetic shift of the exact sum rounds toward minus infinity.
            v_reg    <= V_W'(suma_reg >>> FRAC_BITS) + V_W'(c3_2_reg);
            sv_reg   <= sat_word(V_W'(sumb_reg >>> FRAC_BITS));
            m3_reg   <= m2_reg;
        end
    end

    // Divider setup: a zero or unit w needs no divide, so its result is
    // settled here and carried alongside the divider.
    always_comb begin
        w_one      = (w == V_W'(ONE_Q));
        w_zero     = (w == '0);
        side4.div  = m3_reg.divide && !w_one && !w_zero;
        side4.neg  = v_reg[V_W-1] ^ w[V_W-1];
        if (m3_reg.divide && w_zero) begin
            if (v_reg > 0) begin
                side4.byp = RES_MAX;
            end else if (v_reg < 0) begin
                side4.byp = RES_MIN;
            end else begin
                side4.byp = '0;
            end
        end else begin
            side4.byp = sat_word(v_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num4_reg <= v_reg[V_W-1] ? V_W'(-v_reg) : V_W'(v_reg);
            den4_reg <= w[V_W-1] ? V_W'(-w) : V_W'(w);
            side_reg[0] <= side4;
            for (int k = 1; k < SIDE_N; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            s_reg[0] <= sv_reg;
            for (int k = 1; k < S_N; k++) begin
                s_reg[k] <= s_reg[k-1];
            end
            r_reg <= side_reg[SIDE_N-1].div ? sres[WORD_BITS-1:0]
                                            : side_reg[SIDE_N-1].byp;
        end
    end

    hpt_div #(
        .NUM_W  (V_W),
        .Q_BITS (LANE_Q)
    ) u_div (
        .aclk (aclk),
        .en   (en),
        .num  (num4_reg),
        .den  (den4_reg),
        .quo  (quo),
        .ovf  (ovf)
    );

    // A negative quotient may reach one step further than a positive one.
    always_comb begin
        lim  = side_reg[SIDE_N-1].neg ? LIM_NEG : LIM_POS;
        mag  = (ovf || ({1'b0, quo} > lim)) ? lim : {1'b0, quo};
        sres = side_reg[SIDE_N-1].neg ? -mag : mag;
    end

    assign s_mid = sv_reg;
    assign r_out = r_reg;
    assign s_out = s_reg[S_N-1];

endmodule

// ===== src/hpt_merge.sv =====
module hpt_merge (
    input  logic                           aclk,
    input  logic                           en,
    input  hpt_pkg::word_t                 coef  [4],
    input  hpt_pkg::word_t                 a     [3],
    input  hpt_pkg::word_t                 b     [3],
    input  hpt_pkg::mode_t                 mode,
    input  hpt_pkg::word_t                 s_mid [3],
    output logic signed [hpt_pkg::V_W-1:0] w,
    output logic [hpt_pkg::WORD_BITS-2:0]  t_max,
    output logic                           div_error
);
    import hpt_pkg::*;

    localparam int SIDE_N = RAY_Q + 1;

    typedef struct packed {
        logic ray;
        logic den_zero;
        logic w_err;
    } merge_side_t;

    logic signed [PROD_W-1:0] pw_reg  [3];
    logic [SQ_W-1:0]          bsq_reg [3];
    logic [SQ_W-1:0]          ssq_reg [3];
    word_t                    c3_1_reg;
    word_t                    c3_2_reg;
    mode_t                    m1_reg;
    mode_t                    m2_reg;
    mode_t                    m3_reg;
    logic signed [SUM_W-1:0]  sumw_reg;
    logic [SQ_W-1:0]          den2_reg;
    logic [SQ_W-1:0]          den3_reg;
    logic [SQ_W-1:0]          den4_reg;
    logic [SQ_W-1:0]          den5_reg;
    logic [SQ_W-1:0]          num5_reg;
    logic signed [V_W-1:0]    w_reg;
    logic                     ray4_reg;
    logic                     werr4_reg;
    merge_side_t              side5_reg;
    merge_side_t              side_reg [SIDE_N];
    logic [RAY_Q-1:0]         quo;
    logic                     ovf;
    logic [WORD_BITS-2:0]     t_reg;
    logic                     err_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                pw_reg[j]  <= PROD_W'(coef[j]) * PROD_W'(a[j]);
                bsq_reg[j] <= PROD_W'(b[j]) * PROD_W'(b[j]);
                ssq_reg[j] <= PROD_W'(s_mid[j]) * PROD_W'(s_mid[j]);
            end
            c3_1_reg  <= coef[3];
            m1_reg    <= mode;
            sumw_reg  <= SUM_W'(pw_reg[0]) + SUM_W'(pw_reg[1]) + SUM_W'(pw_reg[2]);
            den2_reg  <= bsq_reg[0] + bsq_reg[1] + bsq_reg[2];
            c3_2_reg  <= c3_1_reg;
            m2_reg    <= m1_reg;
            w_reg     <= V_W'(sumw_reg >>> FRAC_BITS) + V_W'(c3_2_reg);
            den3_reg  <= den2_reg;
            m3_reg    <= m2_reg;
            den4_reg  <= den3_reg;
            ray4_reg  <= m3_reg.ray;
            werr4_reg <= m3_reg.divide && (w_reg == '0);
            num5_reg  <= ssq_reg[0] + ssq_reg[1] + ssq_reg[2];
            den5_reg  <= den4_reg;
            side5_reg <= '{ray: ray4_reg, den_zero: (den4_reg == '0), w_err: werr4_reg};
            side_reg[0] <= side5_reg;
            for (int k = 1; k < SIDE_N; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            if (!side_reg[SIDE_N-1].ray) begin
                t_reg <= '0;
            end else if (side_reg[SIDE_N-1].den_zero || ovf) begin
                t_reg <= RES_MAX[WORD_BITS-2:0];
            end else begin
                t_reg <= quo;
            end
            err_reg <= side_reg[SIDE_N-1].w_err ||
                       (side_reg[SIDE_N-1].ray && side_reg[SIDE_N-1].den_zero);
        end
    end

    hpt_div #(
        .NUM_W  (SQ_W),
        .Q_BITS (RAY_Q)
    ) u_div (
        .aclk (aclk),
        .en   (en),
        .num  (num5_reg),
        .den  (den5_reg),
        .quo  (quo),
        .ovf  (ovf)
    );

    assign w         = w_reg;
    assign t_max     = t_reg;
    assign div_error = err_reg;

endmodule

// ===== src/homogeneous_point_transform.sv =====
// Homogeneous 4x4 transform of points, vectors, normals and rays in signed
// Q16.16. The block takes one request per cycle while its skid register is
// empty; the pipeline depth is set by the restoring dividers (one quotient
// bit per stage) behind the multiply and sum stages. A load request writes
// its matrix entry at acceptance, so every later request sees the new value.
// When the result side stalls, one more result is held in a skid register
// and the pipeline then holds until it drains. Reset loads the identity
// into both the forward and the inverse matrix.
module homogeneous_point_transform (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [2:0]                        s_cmd,
    input  logic [4:0]                        s_entry_index,
    input  hpt_pkg::word_t                    s_entry_value,
    input  hpt_pkg::word_t                    s_a_x,
    input  hpt_pkg::word_t                    s_a_y,
    input  hpt_pkg::word_t                    s_a_z,
    input  hpt_pkg::word_t                    s_b_x,
    input  hpt_pkg::word_t                    s_b_y,
    input  hpt_pkg::word_t                    s_b_z,
    output logic                              m_valid,
    input  logic                              m_ready,
    output hpt_pkg::word_t                    m_r_x,
    output hpt_pkg::word_t                    m_r_y,
    output hpt_pkg::word_t                    m_r_z,
    output hpt_pkg::word_t                    m_s_x,
    output hpt_pkg::word_t                    m_s_y,
    output hpt_pkg::word_t                    m_s_z,
    output logic [hpt_pkg::WORD_BITS-2:0]     m_t_max,
    output logic                              m_div_error
);
    import hpt_pkg::*;

    localparam int LAST_STAGE = LANE_Q + 6;

    logic [WORD_BITS-1:0]    mat_reg [32];
    logic [2:0]              cmd0_reg;
    word_t                   a0_reg [3];
    word_t                   b0_reg [3];
    logic [LAST_STAGE:0]     valid_reg;
    logic                    en;
    logic                    push;
    word_t                   lane_coef [3][4];
    word_t                   w_coef [4];
    word_t                   lane_b [3];
    mode_t                   mode;
    word_t                   s_mid [3];
    word_t                   r_out [3];
    word_t                   s_out [3];
    logic signed [V_W-1:0]   w;
    logic [WORD_BITS-2:0]    t_max;
    logic                    div_error;
    result_t                 res;
    result_t                 out_reg;
    result_t                 skid_reg;
    logic                    out_v_reg;
    logic                    skid_v_reg;

    assign en      = !skid_v_reg;
    assign s_ready = en;
    assign push    = en && valid_reg[LAST_STAGE];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 32; k++) begin
                mat_reg[k] <= (k[1:0] == k[3:2]) ? ONE_Q : '0;
            end
        end else if (s_valid && s_ready && (s_cmd == CMD_LOAD)) begin
            mat_reg[s_entry_index] <= s_entry_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd0_reg  <= s_cmd;
            a0_reg[0] <= s_a_x;
            a0_reg[1] <= s_a_y;
            a0_reg[2] <= s_a_z;
            b0_reg[0] <= s_b_x;
            b0_reg[1] <= s_b_y;
            b0_reg[2] <= s_b_z;
        end
    end

    // Coefficients are read while the request sits in the input register.
    always_comb begin
        mode = '0;
        for (int i = 0; i < 3; i++) begin
            lane_b[i] = '0;
            for (int j = 0; j < 4; j++) begin
                lane_coef[i][j] = '0;
            end
        end
        for (int j = 0; j < 4; j++) begin
            w_coef[j] = '0;
        end
        unique case (cmd0_reg) inside
            CMD_POINT, CMD_RAY: begin
                mode.divide = 1'b1;
                mode.ray    = (cmd0_reg == CMD_RAY);
                for (int i = 0; i < 3; i++) begin
                    lane_b[i] = mode.ray ? b0_reg[i] : '0;
                    for (int j = 0; j < 4; j++) begin
                        lane_coef[i][j] = mat_reg[5'(i * 4 + j)];
                    end
                end
                for (int j = 0; j < 4; j++) begin
                    w_coef[j] = mat_reg[5'(12 + j)];
                end
            end
            CMD_VECTOR: begin
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        lane_coef[i][j] = mat_reg[5'(i * 4 + j)];
                    end
                end
            end
            CMD_NORMAL: begin
                // Transposed upper 3x3 of the inverse.
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        lane_coef[i][j] = mat_reg[5'(16 + i + 4 * j)];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
        hpt_lane u_lane (
            .aclk  (aclk),
            .en    (en),
            .coef  (lane_coef[i]),
            .a     (a0_reg),
            .b     (lane_b),
            .mode  (mode),
            .w     (w),
            .s_mid (s_mid[i]),
            .r_out (r_out[i]),
            .s_out (s_out[i])
        );
    end

    hpt_merge u_merge (
        .aclk      (aclk),
        .en        (en),
        .coef      (w_coef),
        .a         (a0_reg),
        .b         (lane_b),
        .mode      (mode),
        .s_mid     (s_mid),
        .w         (w),
        .t_max     (t_max),
        .div_error (div_error)
    );

    always_comb begin
        res.r_x       = r_out[0];
        res.r_y       = r_out[1];
        res.r_z       = r_out[2];
        res.s_x       = s_out[0];
        res.s_y       = s_out[1];
        res.s_z       = s_out[2];
        res.t_max     = t_max;
        res.div_error = div_error;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            if (en) begin
                valid_reg <= {valid_reg[LAST_STAGE-1:0], s_valid};
            end
            if (!out_v_reg || m_ready) begin
                out_v_reg  <= skid_v_reg || push;
                skid_v_reg <= 1'b0;
            end else if (push) begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_v_reg || m_ready) begin
            out_reg <= skid_v_reg ? skid_reg : res;
        end else if (push) begin
            skid_reg <= res;
        end
    end

    assign m_valid     = out_v_reg;
    assign m_r_x       = out_reg.r_x;
    assign m_r_y       = out_reg.r_y;
    assign m_r_z       = out_reg.r_z;
    assign m_s_x       = out_reg.s_x;
    assign m_s_y       = out_reg.s_y;
    assign m_s_z       = out_reg.s_z;
    assign m_t_max     = out_reg.t_max;
    assign m_div_error = out_reg.div_error;

endmodule

// ===== src/hpt_checker.sv =====
`include "homogeneous_point_transform_macros.svh"

module hpt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input hpt_pkg::word_t                m_r_x,
    input logic [hpt_pkg::WORD_BITS-2:0] m_t_max,
    input logic                          m_div_error
);

    // A stalled result keeps its value.
    `HPT_ASSERT_RST(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_r_x) && $stable(m_t_max) && $stable(m_div_error), "result changed while stalled")

    // Requests are refused only while a result is stuck at the output.
    `HPT_ASSERT_RST(a_ready_only_stalled, aclk, aresetn, !s_ready |-> m_valid, "request refused with output idle")

    // Taking the output frees the skid register at once.
    `HPT_ASSERT_RST(a_skid_drains, aclk, aresetn, m_valid && m_ready && !s_ready |=> s_ready, "skid register did not drain")

    // Reset empties the pipeline and the output.
    `HPT_ASSERT(a_reset_empty, aclk, !aresetn |=> !m_valid && s_ready, "output busy after reset")

endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (.*);

// ===== bench/homogeneous_point_transform_test.sv =====
module homogeneous_point_transform_test;
    import hpt_pkg::*;

    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam logic [4:0] W_DIAG_ENTRY    = 5'd15;
    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_CYCLES = 60;
    localparam int LONG_HOLD    = 200;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [2:0] cmd;
        logic [4:0] idx;
        word_t      val;
        word_t      ax, ay, az, bx, by, bz;
        bit         typed;
        result_t    res;
    } request_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [2:0] s_cmd = '0;
    logic [4:0] s_entry_index = '0;
    word_t s_entry_value = '0;
    word_t s_a_x = '0, s_a_y = '0, s_a_z = '0;
    word_t s_b_x = '0, s_b_y = '0, s_b_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    word_t m_r_x, m_r_y, m_r_z, m_s_x, m_s_y, m_s_z;
    logic [WORD_BITS-2:0] m_t_max;
    logic m_div_error;

    // Side information that travels with the request on the input channel.
    bit      req_typed = 1'b0;
    result_t req_res = '0;

    word_t   matrix_copy [32];
    result_t expected_q [$];
    request_t directed [$];
    int      fail_count = 0;
    bit      no_idle = 1'b0;
    bit      hold_request = 1'b0;

    homogeneous_point_transform dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic wide_t row_dot(word_t c0, word_t c1, word_t c2,
                                      word_t x, word_t y, word_t z);
        wide_t acc;
        acc = wide_t'(c0) * wide_t'(x) + wide_t'(c1) * wide_t'(y)
            + wide_t'(c2) * wide_t'(z);
        return acc >>> FRAC_BITS;
    endfunction

    function automatic word_t sat_res(wide_t v);
        if (v > wide_t'(RES_MAX)) return RES_MAX;
        if (v < wide_t'(RES_MIN)) return RES_MIN;
        return v[WORD_BITS-1:0];
    endfunction

    // Fixed-point quotient of two nonnegative values, clipped at lim.
    function automatic wide_t frac_quotient(wide_t num, wide_t den, wide_t lim);
        wide_t q;
        q = (num <<< FRAC_BITS) / den;
        return (q > lim) ? lim : q;
    endfunction

    function automatic result_t transform_predict(request_t rq);
        result_t res;
        wide_t v [4];
        wide_t num, den, mag;
        bit neg;
        res = '0;
        case (rq.cmd)
            CMD_LOAD: matrix_copy[rq.idx] = rq.val;
            CMD_POINT, CMD_RAY: begin
                for (int i = 0; i < 4; i++)
                    v[i] = row_dot(matrix_copy[4*i], matrix_copy[4*i+1],
                                   matrix_copy[4*i+2], rq.ax, rq.ay, rq.az)
                         + wide_t'(matrix_copy[4*i+3]);
                for (int i = 0; i < 3; i++) begin
                    word_t r;
                    if (v[3] == wide_t'(ONE_Q)) begin
                        r = sat_res(v[i]);
                    end else if (v[3] == 0) begin
                        res.div_error = 1'b1;
                        r = (v[i] > 0) ? RES_MAX : (v[i] < 0) ? RES_MIN : '0;
                    end else begin
                        neg = (v[i] < 0) != (v[3] < 0);
                        mag = frac_quotient(v[i] < 0 ? -v[i] : v[i],
                                            v[3] < 0 ? -v[3] : v[3],
                                            wide_t'(RES_MAX) + (neg ? 1 : 0));
                        r = neg ? word_t'(-mag) : word_t'(mag);
                    end
                    case (i)
                        0: res.r_x = r;
                        1: res.r_y = r;
                        default: res.r_z = r;
                    endcase
                end
                if (rq.cmd == CMD_RAY) begin
                    res.s_x = sat_res(row_dot(matrix_copy[0], matrix_copy[1],
                                      matrix_copy[2], rq.bx, rq.by, rq.bz));
                    res.s_y = sat_res(row_dot(matrix_copy[4], matrix_copy[5],
                                      matrix_copy[6], rq.bx, rq.by, rq.bz));
                    res.s_z = sat_res(row_dot(matrix_copy[8], matrix_copy[9],
                                      matrix_copy[10], rq.bx, rq.by, rq.bz));
                    num = wide_t'(res.s_x) * wide_t'(res.s_x)
                        + wide_t'(res.s_y) * wide_t'(res.s_y)
                        + wide_t'(res.s_z) * wide_t'(res.s_z);
                    den = wide_t'(rq.bx) * wide_t'(rq.bx)
                        + wide_t'(rq.by) * wide_t'(rq.by)
                        + wide_t'(rq.bz) * wide_t'(rq.bz);
                    if (den == 0) begin
                        res.div_error = 1'b1;
                        res.t_max = RES_MAX[WORD_BITS-2:0];
                    end else begin
                        res.t_max = (WORD_BITS-1)'(frac_quotient(num, den,
                                                                 wide_t'(RES_MAX)));
                    end
                end
            end
            CMD_VECTOR: begin
                res.r_x = sat_res(row_dot(matrix_copy[0], matrix_copy[1],
                                  matrix_copy[2], rq.ax, rq.ay, rq.az));
                res.r_y = sat_res(row_dot(matrix_copy[4], matrix_copy[5],
                                  matrix_copy[6], rq.ax, rq.ay, rq.az));
                res.r_z = sat_res(row_dot(matrix_copy[8], matrix_copy[9],
                                  matrix_copy[10], rq.ax, rq.ay, rq.az));
            end
            CMD_NORMAL: begin
                // Normals use the transposed inverse, so coefficients run down columns.
                res.r_x = sat_res(row_dot(matrix_copy[16], matrix_copy[20],
                                  matrix_copy[24], rq.ax, rq.ay, rq.az));
                res.r_y = sat_res(row_dot(matrix_copy[17], matrix_copy[21],
                                  matrix_copy[25], rq.ax, rq.ay, rq.az));
                res.r_z = sat_res(row_dot(matrix_copy[18], matrix_copy[22],
                                  matrix_copy[26], rq.ax, rq.ay, rq.az));
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic bit field_ok(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        request_t rq;
        result_t want, got;
        result_t guess;
        bit ok;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: result with no request outstanding", $time);
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                got = '{m_r_x, m_r_y, m_r_z, m_s_x, m_s_y, m_s_z, m_t_max, m_div_error};
                ok = field_ok("r_x", want.r_x, got.r_x);
                ok &= field_ok("r_y", want.r_y, got.r_y);
                ok &= field_ok("r_z", want.r_z, got.r_z);
                ok &= field_ok("s_x", want.s_x, got.s_x);
                ok &= field_ok("s_y", want.s_y, got.s_y);
                ok &= field_ok("s_z", want.s_z, got.s_z);
                ok &= field_ok("t_max", want.t_max, got.t_max);
                ok &= field_ok("div_error", want.div_error, got.div_error);
                if (!ok) fail_count++;
            end
        end
        if (aresetn && s_valid && s_ready) begin
            rq = '{s_cmd, s_entry_index, s_entry_value, s_a_x, s_a_y, s_a_z,
                   s_b_x, s_b_y, s_b_z, req_typed, req_res};
            guess = transform_predict(rq);
            expected_q.push_back(req_typed ? req_res : guess);
        end
    end

    initial begin
        int gap;
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 13);
            if (hold_request) begin
                hold_request = 1'b0;
                gap = LONG_HOLD;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(aresetn && m_valid)) @(posedge aclk);
        end
    end

    task automatic send(request_t rq);
        s_valid <= 1'b1;
        s_cmd <= rq.cmd;
        s_entry_index <= rq.idx;
        s_entry_value <= rq.val;
        s_a_x <= rq.ax;
        s_a_y <= rq.ay;
        s_a_z <= rq.az;
        s_b_x <= rq.bx;
        s_b_y <= rq.by;
        s_b_z <= rq.bz;
        req_typed <= rq.typed;
        req_res <= rq.res;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic pause_sender();
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic word_t pick_word();
        case ($urandom_range(0, 3))
            0: return word_t'($urandom_range(0, 1 << 19)) - word_t'(1 << 18);
            1: case ($urandom_range(0, 4))
                   0: return '0;
                   1: return ONE_Q;
                   2: return -ONE_Q;
                   3: return RES_MAX;
                   default: return RES_MIN;
               endcase
            default: return word_t'($urandom());
        endcase
    endfunction

    function automatic request_t row(logic [2:0] cmd, logic [4:0] idx, word_t val,
                                     word_t ax, word_t ay, word_t az,
                                     word_t bx, word_t by, word_t bz,
                                     bit typed, result_t res);
        request_t rq;
        rq = '{cmd, idx, val, ax, ay, az, bx, by, bz, typed, res};
        return rq;
    endfunction

    function automatic request_t random_request();
        request_t rq;
        rq = row(CMD_LOAD, 5'($urandom()), pick_word(), pick_word(), pick_word(),
                 pick_word(), pick_word(), pick_word(), pick_word(), 1'b0, '0);
        case ($urandom_range(0, 19))
            0, 1, 2: begin
                // Keep the w row close to affine most of the time.
                if (rq.idx inside {[12:14]} && $urandom_range(0, 1)) rq.val = '0;
                if (rq.idx == W_DIAG_ENTRY && $urandom_range(0, 2) != 0) rq.val = ONE_Q;
            end
            3: rq.cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
            4, 5, 6, 7: rq.cmd = CMD_POINT;
            8, 9, 10: rq.cmd = CMD_VECTOR;
            11, 12, 13: rq.cmd = CMD_NORMAL;
            default: begin
                rq.cmd = CMD_RAY;
                if ($urandom_range(0, 15) == 0) begin
                    rq.bx = '0;
                    rq.by = '0;
                    rq.bz = '0;
                end
            end
        endcase
        return rq;
    endfunction

    initial begin
        result_t zero_res;
        request_t rq;
        zero_res = '0;
        for (int i = 0; i < 32; i++)
            matrix_copy[i] = (i % 16 == 0 || i % 16 == 5 || i % 16 == 10 || i % 16 == 15)
                           ? ONE_Q : '0;

        directed.push_back(row(CMD_POINT, 0, 0, RES_MAX, RES_MIN, 0, 0, 0, 0,
                               1, '{RES_MAX, RES_MIN, 0, 0, 0, 0, 0, 0}));
        directed.push_back(row(CMD_VECTOR, 0, 0, RES_MIN, RES_MAX, ONE_Q, 0, 0, 0,
                               1, '{RES_MIN, RES_MAX, ONE_Q, 0, 0, 0, 0, 0}));
        directed.push_back(row(CMD_NORMAL, 0, 0, -1, 1, RES_MAX, 0, 0, 0,
                               1, '{-1, 1, RES_MAX, 0, 0, 0, 0, 0}));
        directed.push_back(row(CMD_RAY, 0, 0, 0, 0, 0, ONE_Q, 0, 0,
                               1, '{0, 0, 0, ONE_Q, 0, 0, ONE_Q, 0}));
        directed.push_back(row(CMD_RAY, 0, 0, ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, 1,
                               '{ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, RES_MAX[WORD_BITS-2:0], 1}));
        directed.push_back(row(CMD_RAY, 0, 0, RES_MIN, RES_MAX, -1, RES_MAX, RES_MIN,
                               RES_MAX, 0, zero_res));
        directed.push_back(row(CMD_SPARE_FIRST, 31, -1, -1, -1, -1, -1, -1, -1, 1, zero_res));
        directed.push_back(row(CMD_SPARE_LAST, 0, 0, 1, 1, 1, 1, 1, 1, 1, zero_res));
        // A zero w entry makes every point divide by zero.
        directed.push_back(row(CMD_LOAD, W_DIAG_ENTRY, 0, 0, 0, 0, 0, 0, 0, 1, zero_res));
        directed.push_back(row(CMD_POINT, 0, 0, 1, -1, 0, 0, 0, 0,
                               1, '{RES_MAX, RES_MIN, 0, 0, 0, 0, 0, 1}));
        directed.push_back(row(CMD_LOAD, W_DIAG_ENTRY, 2 * ONE_Q, 0, 0, 0, 0, 0, 0,
                               1, zero_res));
        directed.push_back(row(CMD_POINT, 0, 0, 3, -3, RES_MAX, 0, 0, 0, 0, zero_res));
        directed.push_back(row(CMD_LOAD, 0, RES_MAX, 0, 0, 0, 0, 0, 0, 1, zero_res));
        directed.push_back(row(CMD_VECTOR, 0, 0, RES_MAX, 0, 0, 0, 0, 0, 0, zero_res));
        directed.push_back(row(CMD_LOAD, 3, RES_MIN, 0, 0, 0, 0, 0, 0, 1, zero_res));
        directed.push_back(row(CMD_POINT, 0, 0, RES_MIN, RES_MIN, RES_MIN, 0, 0, 0,
                               0, zero_res));
        directed.push_back(row(CMD_LOAD, 12, ONE_Q, 0, 0, 0, 0, 0, 0, 1, zero_res));
        directed.push_back(row(CMD_POINT, 0, 0, -ONE_Q, ONE_Q, 5, 0, 0, 0, 0, zero_res));
        directed.push_back(row(CMD_LOAD, 17, -2 * ONE_Q, 0, 0, 0, 0, 0, 0, 1, zero_res));
        directed.push_back(row(CMD_LOAD, 31, RES_MIN, 0, 0, 0, 0, 0, 0, 1, zero_res));
        directed.push_back(row(CMD_NORMAL, 0, 0, RES_MAX, RES_MIN, ONE_Q, 0, 0, 0,
                               0, zero_res));
        directed.push_back(row(CMD_RAY, 0, 0, 7, -7, RES_MAX, RES_MIN, -1, 1, 0, zero_res));
        directed.push_back(row(CMD_LOAD, 16, 0, 0, 0, 0, 0, 0, 0, 1, zero_res));
        directed.push_back(row(CMD_NORMAL, 0, 0, ONE_Q, ONE_Q, -ONE_Q, 0, 0, 0, 0, zero_res));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            pause_sender();
            send(directed[i]);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = (n % 150) >= 100;
            if (n == 400) begin
                // Keep offering requests while the result side holds off.
                hold_request = 1'b1;
                no_idle = 1'b1;
            end
            if (n == 600) begin
                s_valid <= 1'b0;
                while (expected_q.size() != 0) @(posedge aclk);
            end
            rq = random_request();
            pause_sender();
            send(rq);
        end
        s_valid <= 1'b0;
        no_idle = 1'b0;

        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
